@@ rtl/barycentric_triangle_locate_macros.svh @@
// Assertion macros for the barycentric triangle locator.
`ifndef BARYCENTRIC_TRIANGLE_LOCATE_MACROS_SVH
`define BARYCENTRIC_TRIANGLE_LOCATE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define BTL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("btl assertion failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define BTL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("btl assertion failed");

`endif

@@ rtl/btl_pkg.sv @@
// Shared types and constants of the barycentric triangle locator.
`default_nettype none
package btl_pkg;
    localparam int COORD_BITS = 16;
    localparam int EW    = COORD_BITS + 1;   // edge and offset components
    localparam int DW    = 2 * EW + 3;       // dot products
    localparam int SPLIT = (DW + 1) / 2;     // low half of a split dot product
    localparam int AOW   = DW;               // multiplier operand a
    localparam int BOW   = SPLIT + 1;        // multiplier operand b
    localparam int PW    = AOW + BOW;        // product
    localparam int AW    = 2 * DW + 2;       // accumulator
    localparam int QW    = 16;               // Q1.15 weight

    localparam logic [QW-1:0] ONE_Q15 = 16'h8000;

    localparam logic [1:0] ACT_VERTEX   = 2'd0;
    localparam logic [1:0] ACT_TRIANGLE = 2'd1;
    localparam logic [1:0] ACT_LOCATE   = 2'd2;

    // Accumulation targets; the group counter runs through them in order
    localparam logic [2:0] DST_D00 = 3'd0;
    localparam logic [2:0] DST_D01 = 3'd1;
    localparam logic [2:0] DST_D11 = 3'd2;
    localparam logic [2:0] DST_D20 = 3'd3;
    localparam logic [2:0] DST_D21 = 3'd4;
    localparam logic [2:0] DST_DEN = 3'd5;
    localparam logic [2:0] DST_N2  = 3'd6;
    localparam logic [2:0] DST_N3  = 3'd7;

    typedef struct packed {
        logic       valid;
        logic       clr;    // start a new sum
        logic       sub;    // subtract the term
        logic       hi;     // term is the upper half, weight 2^SPLIT
        logic       last;   // last term of the sum
        logic [2:0] dest;
    } mac_op_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SCAN  = 9'b000000010,
        ST_TRI   = 9'b000000100,
        ST_VTX   = 9'b000001000,
        ST_MAC   = 9'b000010000,
        ST_DRAIN = 9'b000100000,
        ST_TEST  = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;
endpackage
`default_nettype wire

@@ rtl/btl_mac.sv @@
// Shared two-stage signed multiply-accumulate unit.
`default_nettype none
module btl_mac (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire btl_pkg::mac_op_t               op_in,
    input  wire logic signed [btl_pkg::AOW-1:0] opa,
    input  wire logic signed [btl_pkg::BOW-1:0] opb,
    output btl_pkg::mac_op_t                    op_out,
    output logic signed [btl_pkg::AW-1:0]       acc_next
);
    localparam int PW = btl_pkg::PW;
    localparam int AW = btl_pkg::AW;

    btl_pkg::mac_op_t      op_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [AW-1:0]  term;
    logic signed [AW-1:0]  base;

    // Stage one: multiply
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= '0;
        end else begin
            op_reg <= op_in;
        end
        prod_reg <= opa * opb;
    end

    // Stage two: weight the term and add it in
    always_comb begin
        term = {{(AW-PW){prod_reg[PW-1]}}, prod_reg};
        if (op_reg.hi) begin
            term = term <<< btl_pkg::SPLIT;
        end
        base = op_reg.clr ? '0 : acc_reg;
        acc_next = op_reg.sub ? (base - term) : (base + term);
    end

    always_ff @(posedge aclk) begin
        if (op_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign op_out = op_reg;
endmodule
`default_nettype wire

@@ rtl/btl_div.sv @@
// Restoring divider giving floor(num * 2^15 / den), one quotient bit per cycle.
`default_nettype none
module btl_div (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            start,
    input  wire logic [btl_pkg::AW-1:0]    num,
    input  wire logic [btl_pkg::AW-1:0]    den,
    output logic [btl_pkg::QW-1:0]         quot,
    output logic                           done
);
    localparam int AW = btl_pkg::AW;
    localparam int QW = btl_pkg::QW;

    logic [AW:0]             rem_reg;
    logic [QW-1:0]           q_reg;
    logic [$clog2(QW)-1:0]   cnt_reg;
    logic                    busy_reg;
    logic                    first_reg;
    logic                    done_reg;
    logic [AW:0]             trial;
    logic                    ge;

    // The first step tests num itself, later steps the doubled remainder
    always_comb begin
        trial = first_reg ? rem_reg : {rem_reg[AW-1:0], 1'b0};
        ge    = trial >= {1'b0, den};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= {1'b0, num};
            q_reg     <= '0;
            cnt_reg   <= '1;
            first_reg <= 1'b1;
        end else if (busy_reg) begin
            rem_reg   <= ge ? (trial - {1'b0, den}) : trial;
            q_reg     <= {q_reg[QW-2:0], ge};
            cnt_reg   <= cnt_reg - 1'b1;
            first_reg <= 1'b0;
        end
    end

    assign quot = q_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

@@ rtl/barycentric_triangle_locate.sv @@
// Barycentric triangle locator: stores, sequencer, output register and checks.
//
// Load items (vertex or triangle) are written while idle and keep the block
// ready. A locate item walks triangles 0 .. triangle_count-1 and reports the
// first that holds the point. Each triangle takes a scan step, one triangle
// read (the triangle is skipped there when a corner index is out of range),
// four vertex fetch steps, then 27 terms through the one shared
// multiply-accumulate unit (15 for the five dot products, 12 for the
// denominator and the two numerators, each a 37 by 20 bit multiply) plus a
// drain and a compare step. A hit adds two divisions. The block is not ready
// while a query runs. Stores come up undefined; only read loaded entries.
`default_nettype none
`include "barycentric_triangle_locate_macros.svh"
module barycentric_triangle_locate #(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_TRIANGLES = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // slot[9:0], coord_x[25:10], coord_y[41:26], coord_z[57:42],
    // corner_a[67:58], corner_b[77:68], corner_c[87:78]
    input  wire  [87:0] s_tdata,
    // action[1:0]
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // hit_v1[9:0], hit_v2[19:10], hit_v3[29:20], weight_1[45:30],
    // weight_2[61:46], weight_3[77:62], zero[79:78]
    output logic [79:0] m_tdata,
    // found[0]
    output logic [0:0]  m_tuser,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [10:0] cfg_data
);
    localparam int CW    = btl_pkg::COORD_BITS;
    localparam int EW    = btl_pkg::EW;
    localparam int DW    = btl_pkg::DW;
    localparam int SPLIT = btl_pkg::SPLIT;
    localparam int AOW   = btl_pkg::AOW;
    localparam int BOW   = btl_pkg::BOW;
    localparam int AW    = btl_pkg::AW;
    localparam int QW    = btl_pkg::QW;
    localparam int VIW   = $clog2(MAX_VERTICES);
    localparam int TIW   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int TCW   = $clog2(MAX_TRIANGLES + 1);

    btl_pkg::state_t state_reg, state_next;

    logic [10:0]            tcount_reg;
    logic [3*CW-1:0]        vtx_mem [MAX_VERTICES];
    logic [29:0]            tri_mem [MAX_TRIANGLES];
    logic [3*CW-1:0]        vtx_q_reg;
    logic [29:0]            tri_q_reg;
    logic [VIW-1:0]         vaddr;

    logic signed [CW-1:0]   pt_reg [3];
    logic signed [CW-1:0]   va_reg [3];
    logic signed [EW-1:0]   e0_reg [3];
    logic signed [EW-1:0]   e1_reg [3];
    logic signed [EW-1:0]   p_reg  [3];
    logic [9:0]             ca_reg, cb_reg, cc_reg;
    logic [TCW-1:0]         tri_idx_reg;
    logic [1:0]             vcnt_reg;
    logic [2:0]             grp_reg;
    logic [1:0]             term_reg;

    logic signed [DW-1:0]   d00_reg, d01_reg, d11_reg, d20_reg, d21_reg;
    logic signed [AW-1:0]   den_reg, n2_reg, n3_reg;
    logic [QW-1:0]          w2_reg, w3_reg;
    logic                   found_reg;
    logic                   phase_reg;
    logic                   m_tvalid_reg;
    logic [79:0]            m_tdata_reg;
    logic                   m_found_reg;

    logic                   in_acc;
    logic [1:0]             action;
    logic [9:0]             slot;
    logic [31:0]            limit;
    logic                   scan_end;
    logic                   corners_ok;
    logic                   out_free;
    logic                   last_term;
    logic                   hit;
    logic signed [AW:0]     nsum;

    btl_pkg::mac_op_t       mac_in, mac_out;
    logic signed [AOW-1:0]  mac_a;
    logic signed [BOW-1:0]  mac_b;
    logic signed [AW-1:0]   mac_acc;
    logic signed [EW-1:0]   du, dv;
    logic signed [DW-1:0]   wx, wy;

    logic                   div_start;
    logic [AW-1:0]          div_num;
    logic [QW-1:0]          div_q;
    logic                   div_done;

    assign in_acc    = s_tvalid && s_tready;
    assign action    = s_tuser;
    assign slot      = s_tdata[9:0];
    assign s_tready  = (state_reg == btl_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Clamp the searched count to the store depth
    assign limit = (32'(tcount_reg) > 32'(MAX_TRIANGLES)) ? 32'(MAX_TRIANGLES)
                                                           : 32'(tcount_reg);
    assign scan_end = 32'(tri_idx_reg) >= limit;
    assign corners_ok = (32'(tri_q_reg[9:0])   < 32'(MAX_VERTICES)) &&
                        (32'(tri_q_reg[19:10]) < 32'(MAX_VERTICES)) &&
                        (32'(tri_q_reg[29:20]) < 32'(MAX_VERTICES));

    // Inside test: D nonzero, both numerators nonnegative, their sum within D
    assign nsum = {n2_reg[AW-1], n2_reg} + {n3_reg[AW-1], n3_reg};
    assign hit  = (den_reg != '0) && !n2_reg[AW-1] && !n3_reg[AW-1] &&
                  !({den_reg[AW-1], den_reg} < nsum);

    // Vertex read address follows the corner being fetched
    always_comb begin
        case (vcnt_reg)
            2'd0:    vaddr = VIW'(ca_reg);
            2'd1:    vaddr = VIW'(cb_reg);
            default: vaddr = VIW'(cc_reg);
        endcase
    end

    // Stores: single write at load time, registered read
    always_ff @(posedge aclk) begin
        if (in_acc && action == btl_pkg::ACT_VERTEX && 32'(slot) < 32'(MAX_VERTICES)) begin
            vtx_mem[VIW'(slot)] <= s_tdata[57:10];
        end
        vtx_q_reg <= vtx_mem[vaddr];
    end

    always_ff @(posedge aclk) begin
        if (in_acc && action == btl_pkg::ACT_TRIANGLE &&
            32'(slot) < 32'(MAX_TRIANGLES)) begin
            tri_mem[TIW'(slot)] <= s_tdata[87:58];
        end
        tri_q_reg <= tri_mem[TIW'(tri_idx_reg)];
    end

    // Pick the operands of the current accumulation term
    assign last_term = (grp_reg <= btl_pkg::DST_D21) ? (term_reg == 2'd2)
                                                     : (term_reg == 2'd3);
    always_comb begin
        du = e0_reg[term_reg];
        dv = e0_reg[term_reg];
        wx = d00_reg;
        wy = d11_reg;
        case (grp_reg)
            btl_pkg::DST_D00: begin du = e0_reg[term_reg]; dv = e0_reg[term_reg]; end
            btl_pkg::DST_D01: begin du = e0_reg[term_reg]; dv = e1_reg[term_reg]; end
            btl_pkg::DST_D11: begin du = e1_reg[term_reg]; dv = e1_reg[term_reg]; end
            btl_pkg::DST_D20: begin du = p_reg[term_reg];  dv = e0_reg[term_reg]; end
            btl_pkg::DST_D21: begin du = p_reg[term_reg];  dv = e1_reg[term_reg]; end
            btl_pkg::DST_DEN: begin
                wx = term_reg[1] ? d01_reg : d00_reg;
                wy = term_reg[1] ? d01_reg : d11_reg;
            end
            btl_pkg::DST_N2: begin
                wx = term_reg[1] ? d01_reg : d11_reg;
                wy = term_reg[1] ? d21_reg : d20_reg;
            end
            btl_pkg::DST_N3: begin
                wx = term_reg[1] ? d01_reg : d00_reg;
                wy = term_reg[1] ? d20_reg : d21_reg;
            end
            default: begin du = e0_reg[term_reg]; dv = e0_reg[term_reg]; end
        endcase
        mac_in.valid = (state_reg == btl_pkg::ST_MAC);
        mac_in.clr   = (term_reg == 2'd0);
        mac_in.last  = last_term;
        mac_in.dest  = grp_reg;
        if (grp_reg <= btl_pkg::DST_D21) begin
            mac_in.sub = 1'b0;
            mac_in.hi  = 1'b0;
            mac_a = {{(AOW-EW){du[EW-1]}}, du};
            mac_b = {{(BOW-EW){dv[EW-1]}}, dv};
        end else begin
            mac_in.sub = term_reg[1];
            mac_in.hi  = term_reg[0];
            mac_a = wx;
            mac_b = term_reg[0] ? {{(BOW-(DW-SPLIT)){wy[DW-1]}}, wy[DW-1:SPLIT]}
                                : {1'b0, wy[SPLIT-1:0]};
        end
    end

    btl_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_in    (mac_in),
        .opa      (mac_a),
        .opb      (mac_b),
        .op_out   (mac_out),
        .acc_next (mac_acc)
    );

    // Divider starts on a hit for w2, then again for w3
    assign div_start = ((state_reg == btl_pkg::ST_TEST) && hit) ||
                       ((state_reg == btl_pkg::ST_DIV) && div_done && !phase_reg);
    assign div_num   = (state_reg == btl_pkg::ST_TEST) ? n2_reg : n3_reg;

    btl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den_reg),
        .quot    (div_q),
        .done    (div_done)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            btl_pkg::ST_IDLE:
                if (in_acc && action == btl_pkg::ACT_LOCATE) state_next = btl_pkg::ST_SCAN;
            btl_pkg::ST_SCAN:
                state_next = scan_end ? btl_pkg::ST_DONE : btl_pkg::ST_TRI;
            btl_pkg::ST_TRI:
                state_next = corners_ok ? btl_pkg::ST_VTX : btl_pkg::ST_SCAN;
            btl_pkg::ST_VTX:
                if (vcnt_reg == 2'd3) state_next = btl_pkg::ST_MAC;
            btl_pkg::ST_MAC:
                if (grp_reg == btl_pkg::DST_N3 && last_term) state_next = btl_pkg::ST_DRAIN;
            btl_pkg::ST_DRAIN:
                state_next = btl_pkg::ST_TEST;
            btl_pkg::ST_TEST:
                state_next = hit ? btl_pkg::ST_DIV : btl_pkg::ST_SCAN;
            btl_pkg::ST_DIV:
                if (div_done && phase_reg) state_next = btl_pkg::ST_DONE;
            btl_pkg::ST_DONE:
                if (out_free) state_next = btl_pkg::ST_IDLE;
            default:
                state_next = btl_pkg::ST_IDLE;
        endcase
    end

    // Control registers: state, count, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= btl_pkg::ST_IDLE;
            tcount_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                tcount_reg <= cfg_data;
            end
            if (state_reg == btl_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            btl_pkg::ST_IDLE: begin
                if (in_acc && action == btl_pkg::ACT_LOCATE) begin
                    pt_reg[0]   <= s_tdata[25:10];
                    pt_reg[1]   <= s_tdata[41:26];
                    pt_reg[2]   <= s_tdata[57:42];
                    tri_idx_reg <= '0;
                end
            end
            btl_pkg::ST_SCAN: begin
                found_reg <= 1'b0;
            end
            btl_pkg::ST_TRI: begin
                if (corners_ok) begin
                    ca_reg   <= tri_q_reg[9:0];
                    cb_reg   <= tri_q_reg[19:10];
                    cc_reg   <= tri_q_reg[29:20];
                    vcnt_reg <= '0;
                end else begin
                    tri_idx_reg <= tri_idx_reg + 1'b1;
                end
            end
            btl_pkg::ST_VTX: begin
                vcnt_reg <= vcnt_reg + 1'b1;
                for (int k = 0; k < 3; k++) begin
                    case (vcnt_reg)
                        2'd1: va_reg[k] <= vtx_q_reg[k*CW +: CW];
                        2'd2: e0_reg[k] <= EW'(signed'(vtx_q_reg[k*CW +: CW])) - EW'(va_reg[k]);
                        2'd3: begin
                            e1_reg[k] <= EW'(signed'(vtx_q_reg[k*CW +: CW])) - EW'(va_reg[k]);
                            p_reg[k]  <= EW'(pt_reg[k]) - EW'(va_reg[k]);
                        end
                        default: ;
                    endcase
                end
                grp_reg  <= '0;
                term_reg <= '0;
            end
            btl_pkg::ST_MAC: begin
                if (last_term) begin
                    term_reg <= '0;
                    grp_reg  <= grp_reg + 1'b1;
                end else begin
                    term_reg <= term_reg + 1'b1;
                end
            end
            btl_pkg::ST_TEST: begin
                phase_reg <= 1'b0;
                if (!hit) begin
                    tri_idx_reg <= tri_idx_reg + 1'b1;
                end
            end
            btl_pkg::ST_DIV: begin
                if (div_done) begin
                    if (phase_reg) begin
                        w3_reg    <= div_q;
                        found_reg <= 1'b1;
                    end else begin
                        w2_reg    <= div_q;
                        phase_reg <= 1'b1;
                    end
                end
            end
            btl_pkg::ST_DONE: begin
                if (out_free) begin
                    m_found_reg <= found_reg;
                    m_tdata_reg <= found_reg ? {2'b00, w3_reg, w2_reg,
                                                btl_pkg::ONE_Q15 - w2_reg - w3_reg,
                                                cc_reg, cb_reg, ca_reg}
                                             : '0;
                end
            end
            default: ;
        endcase

        // Latch a finished sum into its target
        if (mac_out.valid && mac_out.last) begin
            case (mac_out.dest)
                btl_pkg::DST_D00: d00_reg <= DW'(mac_acc);
                btl_pkg::DST_D01: d01_reg <= DW'(mac_acc);
                btl_pkg::DST_D11: d11_reg <= DW'(mac_acc);
                btl_pkg::DST_D20: d20_reg <= DW'(mac_acc);
                btl_pkg::DST_D21: d21_reg <= DW'(mac_acc);
                btl_pkg::DST_DEN: den_reg <= mac_acc;
                btl_pkg::DST_N2:  n2_reg  <= mac_acc;
                btl_pkg::DST_N3:  n3_reg  <= mac_acc;
                default: ;
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_found_reg;

    `BTL_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && s_tuser == btl_pkg::ACT_LOCATE, !s_tready)
    `BTL_ASSERT_NOW(a_div_on_hit, state_reg == btl_pkg::ST_DIV, den_reg != '0 && !n2_reg[AW-1] && !n3_reg[AW-1])
    `BTL_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0)
endmodule
`default_nettype wire

@@ sim/barycentric_triangle_locate_test.sv @@
// Self-checking testbench for the barycentric triangle locator.
`default_nettype none
module barycentric_triangle_locate_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_NONE = 2'd3;   // unused action, ignored by the block
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int STORE_DEPTH = 1024;

    typedef struct {
        logic [1:0]  act;
        logic [9:0]  slot;
        logic [15:0] x, y, z;
        logic [9:0]  a, b, c;
    } request_t;

    typedef struct packed {
        logic        found;
        logic [9:0]  v1, v2, v3;
        logic [15:0] w1, w2, w3;
    } hit_t;

    typedef struct {
        bit         cfg;
        int         count;
        logic [1:0] act;
        int         slot, x, y, z, a, b, c;
        bit         typed;
        hit_t       want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;

    // Mirror of the block's stores and search count
    int   vtx_x[STORE_DEPTH], vtx_y[STORE_DEPTH], vtx_z[STORE_DEPTH];
    int   tri_a[STORE_DEPTH], tri_b[STORE_DEPTH], tri_c[STORE_DEPTH];
    bit   vtx_loaded[STORE_DEPTH];
    int   loaded_vertices[$];
    int   search_count = 0;
    hit_t pending_hits[$];

    int   errors = 0;
    int   cycles = 0;
    int   burst_left = 0;
    int   hold_asked = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    logic [7:0] ready_pattern = 8'hFF;
    int   pattern_pos = 0;

    barycentric_triangle_locate i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("barycentric_triangle_locate_test: errors");
            $finish;
        end
    end

    // First triangle, in search order, whose barycentric weights all lie in [0, 1]
    function automatic hit_t locate_point(longint px, longint py, longint pz);
        hit_t h;
        int n, ia, ib, ic, q2, q3;
        longint e0x, e0y, e0z, e1x, e1y, e1z, ox, oy, oz;
        logic signed [127:0] d00, d01, d11, d20, d21, den, n2, n3;
        h = '{found: 1'b0, v1: '0, v2: '0, v3: '0, w1: '0, w2: '0, w3: '0};
        n = search_count > STORE_DEPTH ? STORE_DEPTH : search_count;
        for (int t = 0; t < n; t++) begin
            ia = tri_a[t];
            ib = tri_b[t];
            ic = tri_c[t];
            e0x = vtx_x[ib] - vtx_x[ia];
            e0y = vtx_y[ib] - vtx_y[ia];
            e0z = vtx_z[ib] - vtx_z[ia];
            e1x = vtx_x[ic] - vtx_x[ia];
            e1y = vtx_y[ic] - vtx_y[ia];
            e1z = vtx_z[ic] - vtx_z[ia];
            ox = px - vtx_x[ia];
            oy = py - vtx_y[ia];
            oz = pz - vtx_z[ia];
            d00 = e0x * e0x + e0y * e0y + e0z * e0z;
            d01 = e0x * e1x + e0y * e1y + e0z * e1z;
            d11 = e1x * e1x + e1y * e1y + e1z * e1z;
            d20 = ox * e0x + oy * e0y + oz * e0z;
            d21 = ox * e1x + oy * e1y + oz * e1z;
            den = d00 * d11 - d01 * d01;
            n2 = d11 * d20 - d01 * d21;
            n3 = d00 * d21 - d01 * d20;
            // Skip degenerate triangles and points outside
            if (den == 0) continue;
            if (n2 < 0 || n3 < 0 || n2 + n3 > den) continue;
            q2 = int'((n2 <<< 15) / den);
            q3 = int'((n3 <<< 15) / den);
            h.found = 1'b1;
            h.v1 = ia[9:0];
            h.v2 = ib[9:0];
            h.v3 = ic[9:0];
            h.w1 = 16'(32768 - q2 - q3);
            h.w2 = q2[15:0];
            h.w3 = q3[15:0];
            return h;
        end
        return h;
    endfunction

    // Apply one accepted request to the mirror; a locate queues its result
    task automatic absorb(request_t r, bit typed, hit_t want);
        case (r.act)
            btl_pkg::ACT_VERTEX: begin
                vtx_x[r.slot] = $signed(r.x);
                vtx_y[r.slot] = $signed(r.y);
                vtx_z[r.slot] = $signed(r.z);
                if (!vtx_loaded[r.slot])
                    loaded_vertices.insert(loaded_vertices.size(), r.slot);
                vtx_loaded[r.slot] = 1'b1;
            end
            btl_pkg::ACT_TRIANGLE: begin
                tri_a[r.slot] = r.a;
                tri_b[r.slot] = r.b;
                tri_c[r.slot] = r.c;
            end
            btl_pkg::ACT_LOCATE: begin
                if (typed) pending_hits.insert(pending_hits.size(), want);
                else pending_hits.insert(pending_hits.size(),
                                         locate_point($signed(r.x), $signed(r.y),
                                                      $signed(r.z)));
            end
            default: ;
        endcase
    endtask

    // Offer one request in bursts with random gaps; entered and left at a falling edge
    task automatic offer(request_t r, bit typed = 1'b0, hit_t want = '{default: '0});
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser = r.act;
        s_tdata = {r.c, r.b, r.a, r.z, r.y, r.x, r.slot};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        absorb(r, typed, want);
        @(negedge aclk);
    endtask

    // Hold the sender until every result is back and the block is idle
    task automatic settle();
        s_tvalid = 1'b0;
        burst_left = 0;
        while (pending_hits.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_count(int count);
        settle();
        cfg_valid = 1'b1;
        cfg_data = count[10:0];
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        search_count = count;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_coord(bit wide_range);
        if (wide_range) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 6000) - 3000);
    endfunction

    function automatic request_t vertex_request(int slot, bit wide_range);
        request_t r;
        r.act = btl_pkg::ACT_VERTEX;
        r.slot = slot[9:0];
        r.x = pick_coord(wide_range);
        r.y = pick_coord(wide_range);
        r.z = pick_coord(wide_range);
        r.a = 10'($urandom);
        r.b = 10'($urandom);
        r.c = 10'($urandom);
        return r;
    endfunction

    // Triangle over already loaded corners only
    function automatic request_t triangle_request(int slot);
        request_t r;
        r.act = btl_pkg::ACT_TRIANGLE;
        r.slot = slot[9:0];
        r.a = 10'(loaded_vertices[$urandom_range(0, loaded_vertices.size() - 1)]);
        r.b = 10'(loaded_vertices[$urandom_range(0, loaded_vertices.size() - 1)]);
        r.c = 10'(loaded_vertices[$urandom_range(0, loaded_vertices.size() - 1)]);
        r.x = 16'($urandom);
        r.y = 16'($urandom);
        r.z = 16'($urandom);
        return r;
    endfunction

    // Mostly a point inside one of the searched triangles, else anywhere
    function automatic request_t locate_request();
        request_t r;
        int t, ia, ib, ic, fa, fb;
        r.act = btl_pkg::ACT_LOCATE;
        r.slot = 10'($urandom);
        r.a = 10'($urandom);
        r.b = 10'($urandom);
        r.c = 10'($urandom);
        if (search_count > 0 && $urandom_range(0, 3) != 0) begin
            t = $urandom_range(0, (search_count > STORE_DEPTH ? STORE_DEPTH : search_count) - 1);
            ia = tri_a[t];
            ib = tri_b[t];
            ic = tri_c[t];
            fa = $urandom_range(0, 16);
            fb = $urandom_range(0, 16 - fa);
            r.x = 16'(vtx_x[ia] + ((vtx_x[ib] - vtx_x[ia]) * fa + (vtx_x[ic] - vtx_x[ia]) * fb) / 16);
            r.y = 16'(vtx_y[ia] + ((vtx_y[ib] - vtx_y[ia]) * fa + (vtx_y[ic] - vtx_y[ia]) * fb) / 16);
            r.z = 16'(vtx_z[ia] + ((vtx_z[ib] - vtx_z[ia]) * fa + (vtx_z[ic] - vtx_z[ia]) * fb) / 16);
        end else begin
            r.x = pick_coord($urandom_range(0, 1));
            r.y = pick_coord($urandom_range(0, 1));
            r.z = pick_coord($urandom_range(0, 1));
        end
        return r;
    endfunction

    // Stall the result side on a changing pattern, with long holds on request
    always @(negedge aclk) begin
        if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            if (pattern_pos % 32 == 0)
                ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
            m_tready = ready_pattern[pattern_pos % 8];
            pattern_pos++;
        end
    end

    // Compare each result with the oldest pending one
    always @(posedge aclk) begin
        hit_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.found = m_tuser[0];
            got.v1 = m_tdata[9:0];
            got.v2 = m_tdata[19:10];
            got.v3 = m_tdata[29:20];
            got.w1 = m_tdata[45:30];
            got.w2 = m_tdata[61:46];
            got.w3 = m_tdata[77:62];
            if (pending_hits.size() == 0) begin
                errors++;
                $display("%0t: unexpected result found=%0d v=%0d,%0d,%0d w=%0d,%0d,%0d",
                         $realtime, got.found, got.v1, got.v2, got.v3, got.w1, got.w2, got.w3);
            end else begin
                want = pending_hits.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch expected found=%0d v=%0d,%0d,%0d w=%0d,%0d,%0d",
                             $realtime, want.found, want.v1, want.v2, want.v3,
                             want.w1, want.w2, want.w3);
                    $display("%0t:            actual found=%0d v=%0d,%0d,%0d w=%0d,%0d,%0d",
                             $realtime, got.found, got.v1, got.v2, got.v3,
                             got.w1, got.w2, got.w3);
                end
            end
        end
    end

    initial begin
        row_t steer[$];
        request_t r;
        int ntri;
        hit_t none;
        none = '{found: 1'b0, v1: '0, v2: '0, v3: '0, w1: '0, w2: '0, w3: '0};

        // Directed part: extremes, every action, degenerate and unused cases
        steer = '{
            '{1, 0,    ACT_NONE,     0,    0, 0, 0, 0, 0, 0, 0, none},
            '{0, 0,    btl_pkg::ACT_LOCATE,   0,    5, 5, 5, 0, 0, 0, 1, none},
            '{0, 0,    btl_pkg::ACT_VERTEX,   0,    0, 0, 0, 0, 0, 0, 0, none},
            '{0, 0,    btl_pkg::ACT_VERTEX,   1, 1000, 0, 0, 0, 0, 0, 0, none},
            '{0, 0,    btl_pkg::ACT_VERTEX,   2, 0, 1000, 0, 0, 0, 0, 0, none},
            '{0, 0,    btl_pkg::ACT_VERTEX,   3, -32768, -32768, -32768, 0, 0, 0, 0, none},
            '{0, 0,    btl_pkg::ACT_VERTEX,   4, 32767, 32767, 32767, 0, 0, 0, 0, none},
            '{0, 0,    btl_pkg::ACT_VERTEX,   5, 2000, 0, 0, 0, 0, 0, 0, none},
            '{0, 0,    btl_pkg::ACT_VERTEX, 1023, 32767, -32768, 0, 0, 0, 0, 0, none},
            '{0, 0,    btl_pkg::ACT_TRIANGLE, 0,    0, 0, 0, 0, 5, 1, 0, none},
            '{0, 0,    btl_pkg::ACT_TRIANGLE, 1,    0, 0, 0, 0, 1, 2, 0, none},
            '{0, 0,    btl_pkg::ACT_TRIANGLE, 2,    0, 0, 0, 3, 4, 1023, 0, none},
            '{0, 0,    btl_pkg::ACT_TRIANGLE, 1023, 0, 0, 0, 1023, 1, 2, 0, none},
            '{0, 0,    ACT_NONE,   1023, -1, -1, -1, 1023, 1023, 1023, 0, none},
            '{1, 3,    ACT_NONE,     0,    0, 0, 0, 0, 0, 0, 0, none},
            '{0, 0,    btl_pkg::ACT_LOCATE,   0,    0, 0, 0, 0, 0, 0, 1,
              '{1'b1, 10'd0, 10'd1, 10'd2, 16'd32768, 16'd0, 16'd0}},
            '{0, 0,    btl_pkg::ACT_LOCATE,   0, 1000, 0, 0, 0, 0, 0, 1,
              '{1'b1, 10'd0, 10'd1, 10'd2, 16'd0, 16'd32768, 16'd0}},
            '{0, 0,    btl_pkg::ACT_LOCATE,   0,  250, 250, 7, 0, 0, 0, 0, none},
            '{0, 0,    btl_pkg::ACT_LOCATE,   0, 32767, 32767, 32767, 0, 0, 0, 0, none},
            '{0, 0,    btl_pkg::ACT_LOCATE,   0, -32768, -32768, -32768, 0, 0, 0, 0, none},
            '{0, 0,    btl_pkg::ACT_LOCATE,   0,   -5, -5, 0, 0, 0, 0, 0, none},
            '{0, 0,    btl_pkg::ACT_LOCATE,   0, 10000, -20000, 300, 0, 0, 0, 0, none}
        };

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (steer[i]) begin
            if (steer[i].cfg) write_count(steer[i].count);
            else begin
                r.act = steer[i].act;
                r.slot = steer[i].slot[9:0];
                r.x = steer[i].x[15:0];
                r.y = steer[i].y[15:0];
                r.z = steer[i].z[15:0];
                r.a = steer[i].a[9:0];
                r.b = steer[i].b[9:0];
                r.c = steer[i].c[9:0];
                offer(r, steer[i].typed, steer[i].want);
            end
        end

        // Random phases: fresh vertices and triangles, then a burst of queries
        for (int phase = 0; phase < 6; phase++) begin
            repeat ($urandom_range(3, 7)) offer(vertex_request($urandom_range(0, 1023),
                                                                $urandom_range(0, 4) == 0));
            ntri = $urandom_range(2, 6);
            for (int t = 0; t < ntri; t++) offer(triangle_request(t));
            write_count(phase == 0 ? ntri : $urandom_range(1, ntri));
            if (phase == 2) hold_asked++;
            for (int q = 0; q < 11; q++) begin
                if (phase == 4 && q == 6) settle();
                case ($urandom_range(0, 19))
                    0: begin
                        r = vertex_request($urandom_range(0, 1023), 1'b1);
                        r.act = ACT_NONE;
                        offer(r);
                    end
                    1: offer(vertex_request($urandom_range(0, 1023), 1'b0));
                    default: offer(locate_request());
                endcase
            end
        end

        // Short search over the first two entries
        write_count(2);
        repeat (4) offer(locate_request());

        s_tvalid = 1'b0;
        while (pending_hits.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (errors == 0) $display("barycentric_triangle_locate_test: clean");
        else $display("barycentric_triangle_locate_test: errors");
        $finish;
    end
endmodule
`default_nettype wire
